// ----- src/itsm_pkg.sv -----
// Shared types, constants and divide-step helpers for the tile source mapper.
package itsm_pkg;

  localparam int unsigned MAX_DIM = 4096;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned REM_W   = 14;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_TILE = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE   = 2'd2;

  // per-axis tiling, derived from size and tile factor
  typedef struct packed {
    logic [DIM_W-1:0] q;     // size / n
    logic [REM_W-1:0] qp1;   // q + 1, width of the wide tiles
    logic [DIM_W-1:0] span;  // pixels covered by the wide tiles
  } axis_cfg_t;

  // pipeline advance enables shared with the axis datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem_in, logic bit_in,
                                              logic [REM_W-1:0] dvs);
    logic [REM_W:0] t;
    logic [REM_W:0] d;
    logic           ge;
    t  = {rem_in, bit_in};
    d  = t - {1'b0, dvs};
    ge = (t >= {1'b0, dvs});
    return ge ? {1'b1, d[REM_W-1:0]} : {1'b0, t[REM_W-1:0]};
  endfunction

  // Four restoring steps, msb first.
  function automatic logic [REM_W-1:0] rem_steps4(logic [REM_W-1:0] rem_in, logic [3:0] bits,
                                                  logic [REM_W-1:0] dvs);
    logic [REM_W:0]   r;
    logic [REM_W-1:0] acc;
    acc = rem_in;
    for (int i = 3; i >= 0; i--) begin
      r   = div_step(acc, bits[i], dvs);
      acc = r[REM_W-1:0];
    end
    return acc;
  endfunction

endpackage

// ----- src/itsm_cfg_calc.sv -----
// Serial divider that derives tile width, remainder span and validity from the registers.
module itsm_cfg_calc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [itsm_pkg::DIM_W-1:0]      image_width,
  input  logic [itsm_pkg::DIM_W-1:0]      image_height,
  input  logic [itsm_pkg::DIM_W-1:0]      tile_factor,
  output itsm_pkg::axis_cfg_t             cfg_x,
  output itsm_pkg::axis_cfg_t             cfg_y,
  output logic                            cfg_bad,
  output logic                            busy
);
  import itsm_pkg::*;

  typedef enum logic [3:0] {
    CALC_LOAD = 4'b0001,
    CALC_DIV  = 4'b0010,
    CALC_SPAN = 4'b0100,
    CALC_IDLE = 4'b1000
  } calc_state_t;

  calc_state_t      state;
  logic [3:0]       cnt;
  logic [DIM_W-1:0] dvw;
  logic [DIM_W-1:0] dvh;
  logic [DIM_W-1:0] rw;
  logic [DIM_W-1:0] rh;
  logic [DIM_W-1:0] qw;
  logic [DIM_W-1:0] qh;

  logic [REM_W:0]   stepw;
  logic [REM_W:0]   steph;
  logic [REM_W-1:0] qw_p1;
  logic [REM_W-1:0] qh_p1;
  logic [DIM_W+REM_W-1:0] spanw;
  logic [DIM_W+REM_W-1:0] spanh;

  assign stepw = div_step({1'b0, rw}, dvw[DIM_W-1], {1'b0, tile_factor});
  assign steph = div_step({1'b0, rh}, dvh[DIM_W-1], {1'b0, tile_factor});
  assign qw_p1 = {1'b0, qw} + REM_W'(1);
  assign qh_p1 = {1'b0, qh} + REM_W'(1);
  assign spanw = (DIM_W+REM_W)'(rw) * (DIM_W+REM_W)'(qw_p1);
  assign spanh = (DIM_W+REM_W)'(rh) * (DIM_W+REM_W)'(qh_p1);

  assign busy = (state != CALC_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CALC_LOAD;
      cnt   <= '0;
    end else if (start) begin
      state <= CALC_LOAD;
    end else begin
      case (state)
        CALC_LOAD: begin
          state <= CALC_DIV;
          cnt   <= 4'(DIM_W - 1);
        end
        CALC_DIV: begin
          if (cnt == '0) state <= CALC_SPAN;
          else cnt <= cnt - 4'd1;
        end
        CALC_SPAN: state <= CALC_IDLE;
        CALC_IDLE: state <= CALC_IDLE;
        default:   state <= CALC_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CALC_LOAD: begin
        dvw <= image_width;
        dvh <= image_height;
        rw  <= '0;
        rh  <= '0;
        qw  <= '0;
        qh  <= '0;
      end
      CALC_DIV: begin
        dvw <= {dvw[DIM_W-2:0], 1'b0};
        dvh <= {dvh[DIM_W-2:0], 1'b0};
        rw  <= stepw[DIM_W-1:0];
        rh  <= steph[DIM_W-1:0];
        qw  <= {qw[DIM_W-2:0], stepw[REM_W]};
        qh  <= {qh[DIM_W-2:0], steph[REM_W]};
      end
      CALC_SPAN: begin
        cfg_x.q    <= qw;
        cfg_x.qp1  <= qw_p1;
        cfg_x.span <= spanw[DIM_W-1:0];
        cfg_y.q    <= qh;
        cfg_y.qp1  <= qh_p1;
        cfg_y.span <= spanh[DIM_W-1:0];
        cfg_bad    <= (tile_factor == '0) || (qw == '0) || (qh == '0) ||
                      (image_width > DIM_W'(MAX_DIM)) || (image_height > DIM_W'(MAX_DIM));
      end
      default: begin
      end
    endcase
  end

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start |=> state == CALC_LOAD) else $error("write did not restart tile calc");
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == CALC_DIV) && (cnt == '0) && !start |=> state == CALC_SPAN)
    else $error("divide did not finish after last step");
  a_span_idle: assert property (@(posedge clk) disable iff (rst)
    (state == CALC_SPAN) && !start |=> !busy) else $error("tile calc stuck after span");

endmodule

// ----- src/itsm_axis.sv -----
// One axis: tile select, pipelined remainder by tile width, and scale by tile factor.
module itsm_axis (
  input  logic                            clk,
  input  itsm_pkg::stage_en_t             en,
  input  logic [itsm_pkg::COORD_W-1:0]    pos,
  input  logic [itsm_pkg::DIM_W-1:0]      tile_factor,
  input  itsm_pkg::axis_cfg_t             cfg,
  output logic [itsm_pkg::COORD_W-1:0]    src
);
  import itsm_pkg::*;

  logic [COORD_W-1:0] dvd1;
  logic               wide1;
  logic [7:0]         dvd2;
  logic               wide2;
  logic [REM_W-1:0]   rem2;
  logic [3:0]         dvd3;
  logic               wide3;
  logic [REM_W-1:0]   rem3;
  logic [REM_W-1:0]   rem4;

  logic               wide0;
  logic [DIM_W-1:0]   rest0;
  logic [REM_W-1:0]   dvs1;
  logic [REM_W-1:0]   dvs2;
  logic [REM_W-1:0]   dvs3;
  logic [DIM_W+REM_W-1:0] scaled;

  // pixels past the wide tiles are counted from the end of that span
  assign wide0  = {1'b0, pos} < cfg.span;
  assign rest0  = {1'b0, pos} - cfg.span;
  assign dvs1   = wide1 ? cfg.qp1 : {1'b0, cfg.q};
  assign dvs2   = wide2 ? cfg.qp1 : {1'b0, cfg.q};
  assign dvs3   = wide3 ? cfg.qp1 : {1'b0, cfg.q};
  assign scaled = (DIM_W+REM_W)'(rem4) * (DIM_W+REM_W)'(tile_factor);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dvd1  <= wide0 ? pos : rest0[COORD_W-1:0];
      wide1 <= wide0;
    end
    if (en.s2) begin
      rem2  <= rem_steps4('0, dvd1[11:8], dvs1);
      dvd2  <= dvd1[7:0];
      wide2 <= wide1;
    end
    if (en.s3) begin
      rem3  <= rem_steps4(rem2, dvd2[7:4], dvs2);
      dvd3  <= dvd2[3:0];
      wide3 <= wide2;
    end
    if (en.s4) begin
      rem4 <= rem_steps4(rem3, dvd3, dvs3);
    end
    if (en.s5) begin
      src <= scaled[COORD_W-1:0];
    end
  end

endmodule

// ----- src/image_tile_source_mapper.sv -----
// Top level of the tile source mapper: register port, pipeline control and address stage.
// Takes one pixel coordinate word per clock and returns one source word per clock while the
// sink accepts and no recompute runs; tready follows the output side through the pipeline.
// After reset and after every register write a one-bit-per-cycle divider recomputes the tile
// widths, and s_tready stays low while it runs. Status 1 flags a bad tile factor or an image
// over 4096 on a side, status 2 a coordinate outside the image; both read zero source fields.
module image_tile_source_mapper (
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // coordinate stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // out_x[11:0], out_y[23:12]
  // source stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // src_x[11:0], src_y[23:12], src_addr[47:24]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import itsm_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] tile_factor;

  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  axis_cfg_t        cfg_x;
  axis_cfg_t        cfg_y;
  logic             cfg_bad;
  logic             cfg_busy;

  logic [7:1]       v;
  logic [7:1]       en;
  stage_en_t        axis_en;
  logic             s_accept;

  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [1:0]         stat0;
  logic [1:0]         stat [1:6];
  logic [COORD_W-1:0] sx5;
  logic [COORD_W-1:0] sy5;
  logic [COORD_W-1:0] sx6;
  logic [COORD_W-1:0] sy6;
  logic [ADDR_W-1:0]  prod6;
  logic [ADDR_W:0]    prod_full;
  logic [ADDR_W-1:0]  addr7;

  // register port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      tile_factor  <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_TILE:   tile_factor  <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = {19'b0, image_width};
      REG_HEIGHT: prdata = {19'b0, image_height};
      REG_TILE:   prdata = {19'b0, tile_factor};
      default:    prdata = '0;
    endcase
  end

  itsm_cfg_calc u_cfg (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_wr),
    .image_width  (image_width),
    .image_height (image_height),
    .tile_factor  (tile_factor),
    .cfg_x        (cfg_x),
    .cfg_y        (cfg_y),
    .cfg_bad      (cfg_bad),
    .busy         (cfg_busy)
  );

  // pipeline advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[7] = !v[7] || m_tready;
    for (int i = 6; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign axis_en  = '{s1: en[1], s2: en[2], s3: en[3], s4: en[4], s5: en[5]};
  assign s_tready = en[1] && !cfg_busy;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_accept;
      for (int i = 2; i <= 7; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign in_x = s_tdata[11:0];
  assign in_y = s_tdata[23:12];

  always_comb begin
    if (cfg_bad) stat0 = STAT_BAD_TILE;
    else if (({1'b0, in_x} >= image_width) || ({1'b0, in_y} >= image_height))
      stat0 = STAT_OUTSIDE;
    else stat0 = STAT_OK;
  end

  always_ff @(posedge clk) begin
    if (en[1]) stat[1] <= stat0;
    for (int i = 2; i <= 6; i++) begin
      if (en[i]) stat[i] <= stat[i-1];
    end
  end

  itsm_axis u_axis_x (
    .clk         (clk),
    .en          (axis_en),
    .pos         (in_x),
    .tile_factor (tile_factor),
    .cfg         (cfg_x),
    .src         (sx5)
  );

  itsm_axis u_axis_y (
    .clk         (clk),
    .en          (axis_en),
    .pos         (in_y),
    .tile_factor (tile_factor),
    .cfg         (cfg_y),
    .src         (sy5)
  );

  assign prod_full = (ADDR_W+1)'(sy5) * (ADDR_W+1)'(image_width);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      prod6 <= prod_full[ADDR_W-1:0];
      sx6   <= sx5;
      sy6   <= sy5;
    end
  end

  assign addr7 = prod6 + {12'b0, sx6};

  // error words carry zero coordinates
  always_ff @(posedge clk) begin
    if (en[7]) begin
      m_tuser <= stat[6];
      m_tdata <= (stat[6] == STAT_OK) ? {addr7, sy6, sx6} : '0;
    end
  end

  assign m_tvalid = v[7];

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_busy |-> !s_tready) else $error("word accepted during tile calc");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_OK) |-> m_tdata == '0) else $error("error word not zeroed");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> v[1]) else $error("accepted word lost at entry");

endmodule

// ----- dv/image_tile_source_mapper_tb.sv -----
// Self-checking testbench for the tile source mapper: APB setup, coordinate stream, scoreboard.
`timescale 1ns / 100ps

module image_tile_source_mapper_tb;
  import itsm_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped register slot

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] src_addr;
    logic [11:0]       src_y;
    logic [11:0]       src_x;
  } src_word_t;

  class src_scoreboard;
    int unsigned img_w;
    int unsigned img_h;
    int unsigned tiles;
    src_word_t   due_q[$];
    int unsigned mismatches;

    function new();
      img_w = 640;
      img_h = 480;
      tiles = 1;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WIDTH:  img_w = value[DIM_W-1:0];
        REG_HEIGHT: img_h = value[DIM_W-1:0];
        REG_TILE:   tiles = value[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // source offset along one axis; caller guarantees size >= n >= 1 and pos < size
    function int unsigned axis_origin(int unsigned pos, int unsigned size, int unsigned n);
      int unsigned q;
      int unsigned wide;
      int unsigned off;
      q = size / n;
      wide = (size % n) * (q + 1);
      if (pos < wide) off = pos % (q + 1);
      else off = (pos - wide) % q;
      return off * n;
    endfunction

    function src_word_t map_coord(logic [11:0] ox, logic [11:0] oy);
      src_word_t r;
      int unsigned sx;
      int unsigned sy;
      r = '0;
      if (tiles == 0 || img_w / tiles == 0 || img_h / tiles == 0 ||
          img_w > MAX_DIM || img_h > MAX_DIM) begin
        r.status = STAT_BAD_TILE;
      end else if (ox >= img_w || oy >= img_h) begin
        r.status = STAT_OUTSIDE;
      end else begin
        sx = axis_origin(ox, img_w, tiles);
        sy = axis_origin(oy, img_h, tiles);
        r.src_x = sx[11:0];
        r.src_y = sy[11:0];
        r.src_addr = ADDR_W'(sy * img_w + sx);
        r.status = STAT_OK;
      end
      return r;
    endfunction

    function void note_coord(logic [23:0] tdata);
      due_q.push_back(map_coord(tdata[11:0], tdata[23:12]));
    endfunction

    function void check_src(logic [47:0] tdata, logic [1:0] tuser);
      src_word_t got;
      src_word_t exp;
      got = {tuser, tdata};
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected source word x=%0d y=%0d addr=%0d status=%0d",
                   $time, got.src_x, got.src_y, got.src_addr, got.status);
        return;
      end
      exp = due_q.pop_front();
      if (got.src_x !== exp.src_x || got.src_y !== exp.src_y ||
          got.src_addr !== exp.src_addr || got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp x=%0d y=%0d addr=%0d status=%0d,",
                   $time, exp.src_x, exp.src_y, exp.src_addr, exp.status,
                   " got x=%0d y=%0d addr=%0d status=%0d",
                   got.src_x, got.src_y, got.src_addr, got.status);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // out_x[11:0], out_y[23:12]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // src_x[11:0], src_y[23:12], src_addr[47:24]
  logic [1:0]  m_tuser;   // status[1:0]

  src_scoreboard sb;
  bit            calm;    // no idling on either side while set
  int unsigned   stall_cycles;

  image_tile_source_mapper u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sink side back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 18);
  end

  // both handshakes sampled with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_coord(s_tdata);
      if (m_tvalid && m_tready) sb.check_src(m_tdata, m_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [DIM_W-1:0] value);
    logic [31:0] word;
    word = {19'($urandom_range(32'h7FFFF, 0)), value};  // upper bits must be ignored
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, word);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // registers change only with the pipe empty
  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned n);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_WIDTH, w[DIM_W-1:0]);
    apb_write(REG_HEIGHT, h[DIM_W-1:0]);
    apb_write(REG_TILE, n[DIM_W-1:0]);
  endtask

  // each cycle idles with the same odds
  task automatic send_coord(logic [11:0] x, logic [11:0] y);
    while (!calm && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(9))
      0: return $urandom_range(8, 1);
      1: return MAX_DIM;
      2: return $urandom_range(8191, MAX_DIM + 1);  // oversized
      default: return $urandom_range(MAX_DIM, 1);
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned lim;
    logic [11:0] x;
    logic [11:0] y;
    w = pick_dim();
    h = pick_dim();
    lim = (w < h) ? w : h;
    case ($urandom_range(9))
      0: n = 0;
      1: n = $urandom_range(8191, lim + 1);   // more tiles than pixels
      2, 3, 4, 5: n = $urandom_range((lim < 16) ? lim : 16, 1);
      default: n = $urandom_range(lim, 1);
    endcase
    set_geometry(w, h, n);
    repeat (count) begin
      x = $urandom_range(4095, 0);
      y = $urandom_range(4095, 0);
      if (w <= MAX_DIM && h <= MAX_DIM && $urandom_range(99) < 85) begin
        x = $urandom_range(w - 1, 0);
        y = $urandom_range(h - 1, 0);
      end
      send_coord(x, y);
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset geometry 640x480, one tile
    send_coord(0, 0);
    send_coord(639, 479);
    send_coord(640, 0);
    send_coord(0, 480);
    send_coord(4095, 4095);
    send_coord(321, 17);
    // largest image, largest address
    set_geometry(4096, 4096, 1);
    send_coord(4095, 4095);
    send_coord(0, 4095);
    send_coord(2048, 1);
    // uneven tiles: one wide tile then narrow ones
    set_geometry(4096, 4096, 3);
    send_coord(1365, 1366);
    send_coord(1366, 2731);
    send_coord(4095, 0);
    // zero tile factor
    set_geometry(4096, 4096, 0);
    send_coord(0, 0);
    send_coord(5, 5);
    // oversized width
    set_geometry(8191, 4096, 3);
    send_coord(0, 0);
    // fewer pixels than tiles, plus a write to the unmapped slot
    set_geometry(5, 100, 6);
    apb_write(REG_SPARE, 13'h1FFF);
    send_coord(1, 1);
    // zero width
    set_geometry(0, 10, 1);
    send_coord(0, 0);
    // single pixel image
    set_geometry(1, 1, 1);
    send_coord(0, 0);
    send_coord(1, 0);
    send_coord(0, 1);
    // one pixel per tile on x, mixed on y
    set_geometry(7, 9, 7);
    send_coord(6, 8);
    send_coord(3, 3);

    for (int p = 0; p < 17; p++) begin
      calm = (p >= 6 && p <= 9);
      random_phase(50);
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
